// ===== hdl/wmm_pkg.sv =====
// ----------------------------------------------------------------------------
// wmm_pkg: shared types and constants of the wildcard mask matcher
// Opcodes, mask metacharacters and the command and status records that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wmm_pkg;

  localparam logic [1:0] OP_MASK = 2'd0;
  localparam logic [1:0] OP_SUBJ = 2'd1;
  localparam logic [1:0] OP_EVAL = 2'd2;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_START,
    DP_STAR,
    DP_PCT,
    DP_QM,
    DP_ADV,
    DP_ADV2,
    DP_BT_PCT,
    DP_BT_STAR,
    DP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   esc_rd;   // read the mask byte after the current one
    logic   esc_cmp;  // compare against the escaped character
  } dp_cmd_t;

  typedef struct packed {
    logic c_star;
    logic c_pct;
    logic c_qm;
    logic c_bs;
    logic c_zero;
    logic s_zero;
    logic nx_lit;
    logic eq;
    logic pct_live;
    logic star_live;
    logic just;
    logic star_end;
    logic ovf;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/wmm_ram.sv =====
// ----------------------------------------------------------------------------
// wmm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/wmm_dp.sv =====
// ----------------------------------------------------------------------------
// wmm_dp: datapath of the wildcard mask matcher
// Mask and subject stores, fill counts, walk pointers, resume points and the
// case-folding byte compare.
// ----------------------------------------------------------------------------
`default_nettype none

module wmm_dp import wmm_pkg::*; #(
  parameter int MASK_DEPTH    = 64,
  parameter int SUBJECT_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_data_byte,
  input  wire dp_cmd_t    cmd,
  output dp_stat_t        stat
);

  localparam int MAW = $clog2(MASK_DEPTH);
  localparam int SAW = $clog2(SUBJECT_DEPTH);
  localparam int MLW = $clog2(MASK_DEPTH + 1);
  localparam int SLW = $clog2(SUBJECT_DEPTH + 1);

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  logic [MLW-1:0] mlen_r, mlen_nxt, m_r, m_nxt, pm_r, pm_nxt, ma_r, ma_nxt, m_rd;
  logic [SLW-1:0] slen_r, slen_nxt, n_r, n_nxt, pn_r, pn_nxt, na_r, na_nxt;
  logic           ovf_r, ovf_nxt;
  logic           pct_r, pct_nxt, star_r, star_nxt, just_r, just_nxt, chk_r, chk_nxt;
  logic           mvld_r, svld_r;
  logic [7:0]     m_rdata, s_rdata, c_raw, s_byte, c_eff;
  logic           nonzero, m_full, s_full, m_we, s_we, nx_lit, pct_eff, s_space;

  assign nonzero = (in_data_byte != 8'd0);
  assign m_full  = (mlen_r == MLW'(MASK_DEPTH));
  assign s_full  = (slen_r == SLW'(SUBJECT_DEPTH));
  assign m_we    = (cmd.op == DP_LOAD) && (in_opcode == OP_MASK) && nonzero && !m_full;
  assign s_we    = (cmd.op == DP_LOAD) && (in_opcode == OP_SUBJ) && nonzero && !s_full;
  assign m_rd    = cmd.esc_rd ? m_r + MLW'(1) : m_r;

  wmm_ram #(.WIDTH(8), .DEPTH(MASK_DEPTH)) u_mask_ram (
    .clk     (clk),
    .we      (m_we),
    .waddr   (mlen_r[MAW-1:0]),
    .wdata   (in_data_byte),
    .raddr   (m_rd[MAW-1:0]),
    .rdata_r (m_rdata)
  );

  wmm_ram #(.WIDTH(8), .DEPTH(SUBJECT_DEPTH)) u_subj_ram (
    .clk     (clk),
    .we      (s_we),
    .waddr   (slen_r[SAW-1:0]),
    .wdata   (in_data_byte),
    .raddr   (n_r[SAW-1:0]),
    .rdata_r (s_rdata)
  );

  // Entries at or past the fill count read as zero.
  assign c_raw   = mvld_r ? m_rdata : 8'd0;
  assign s_byte  = svld_r ? s_rdata : 8'd0;
  assign nx_lit  = (c_raw == CH_STAR) || (c_raw == CH_QMARK);
  assign c_eff   = cmd.esc_cmp ? (nx_lit ? c_raw : CH_BSLASH) : c_raw;
  assign s_space = (s_byte == CH_SPACE);
  // A '%' resume that lands on a space is dropped here.
  assign pct_eff = pct_r && !(chk_r && s_space);

  always_comb begin
    stat.c_star    = (c_raw == CH_STAR);
    stat.c_pct     = (c_raw == CH_PCT);
    stat.c_qm      = (c_raw == CH_QMARK);
    stat.c_bs      = (c_raw == CH_BSLASH);
    stat.c_zero    = (c_raw == 8'd0);
    stat.s_zero    = (s_byte == 8'd0);
    stat.nx_lit    = nx_lit;
    stat.eq        = (fold(c_eff) == fold(s_byte));
    stat.pct_live  = pct_eff;
    stat.star_live = star_r;
    stat.just      = just_r;
    stat.star_end  = ((na_r + SLW'(1)) >= slen_r);
    stat.ovf       = ovf_r;
  end

  always_comb begin
    mlen_nxt = mlen_r;
    slen_nxt = slen_r;
    ovf_nxt  = ovf_r;
    m_nxt    = m_r;
    n_nxt    = n_r;
    pm_nxt   = pm_r;
    pn_nxt   = pn_r;
    ma_nxt   = ma_r;
    na_nxt   = na_r;
    pct_nxt  = pct_r;
    star_nxt = star_r;
    just_nxt = just_r;
    chk_nxt  = chk_r;
    case (cmd.op)
      DP_LOAD: begin
        if (m_we) mlen_nxt = mlen_r + MLW'(1);
        if (s_we) slen_nxt = slen_r + SLW'(1);
        if (nonzero && ((in_opcode == OP_MASK && m_full) ||
                        (in_opcode == OP_SUBJ && s_full))) begin
          ovf_nxt = 1'b1;
        end
      end
      DP_START: begin
        m_nxt    = '0;
        n_nxt    = '0;
        pct_nxt  = 1'b0;
        star_nxt = 1'b0;
        just_nxt = 1'b0;
        chk_nxt  = 1'b0;
      end
      DP_STAR: begin
        m_nxt    = m_r + MLW'(1);
        ma_nxt   = m_r + MLW'(1);
        na_nxt   = n_r;
        star_nxt = 1'b1;
        just_nxt = 1'b1;
        pct_nxt  = pct_eff;
        chk_nxt  = 1'b0;
      end
      DP_PCT: begin
        m_nxt   = m_r + MLW'(1);
        pm_nxt  = m_r + MLW'(1);
        pn_nxt  = n_r;
        pct_nxt = !s_space;
        chk_nxt = 1'b0;
      end
      DP_QM: begin
        m_nxt   = m_r + MLW'(1);
        n_nxt   = n_r + SLW'(1);
        pct_nxt = pct_eff;
        chk_nxt = 1'b0;
      end
      DP_ADV: begin
        m_nxt    = m_r + MLW'(1);
        n_nxt    = n_r + SLW'(1);
        just_nxt = 1'b0;
        pct_nxt  = pct_eff;
        chk_nxt  = 1'b0;
      end
      DP_ADV2: begin
        m_nxt    = m_r + MLW'(2);
        n_nxt    = n_r + SLW'(1);
        just_nxt = 1'b0;
        pct_nxt  = pct_eff;
        chk_nxt  = 1'b0;
      end
      DP_BT_PCT: begin
        m_nxt    = pm_r;
        pn_nxt   = pn_r + SLW'(1);
        n_nxt    = pn_r + SLW'(1);
        just_nxt = 1'b0;
        chk_nxt  = 1'b1;
      end
      DP_BT_STAR: begin
        m_nxt    = ma_r;
        na_nxt   = na_r + SLW'(1);
        n_nxt    = na_r + SLW'(1);
        just_nxt = 1'b0;
        pct_nxt  = pct_eff;
        chk_nxt  = 1'b0;
      end
      DP_CLEAR: begin
        mlen_nxt = '0;
        slen_nxt = '0;
        ovf_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mlen_r <= '0;
      slen_r <= '0;
      ovf_r  <= 1'b0;
      pct_r  <= 1'b0;
      star_r <= 1'b0;
      just_r <= 1'b0;
      chk_r  <= 1'b0;
    end else begin
      mlen_r <= mlen_nxt;
      slen_r <= slen_nxt;
      ovf_r  <= ovf_nxt;
      pct_r  <= pct_nxt;
      star_r <= star_nxt;
      just_r <= just_nxt;
      chk_r  <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    n_r    <= n_nxt;
    pm_r   <= pm_nxt;
    pn_r   <= pn_nxt;
    ma_r   <= ma_nxt;
    na_r   <= na_nxt;
    mvld_r <= (m_rd < mlen_r);
    svld_r <= (n_r < slen_r);
  end

endmodule

`default_nettype wire

// ===== hdl/wmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// wmm_ctrl: controller of the wildcard mask matcher
// Accepts load and evaluate transactions, sequences the backtracking walk
// over the datapath and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wmm_ctrl import wmm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic [1:0] in_opcode,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic            out_matched,
  output logic            out_overflow,
  output dp_cmd_t         cmd,
  input  wire dp_stat_t   stat
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EV   = 5'b00100,
    S_ESC  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   res_r, res_nxt;
  logic   out_valid_r, out_match_r, out_ovf_r;
  logic   slot_free;
  logic   miss_fail;
  dp_op_t miss_op;

  assign in_tready    = (state_r == S_IDLE);
  assign out_tvalid   = out_valid_r;
  assign out_matched  = out_match_r;
  assign out_overflow = out_ovf_r;
  assign slot_free    = !out_valid_r || out_tready;

  // Mismatch: resume at the '%' point first, then at the '*' point.
  always_comb begin
    miss_fail = 1'b0;
    miss_op   = DP_NOP;
    if (stat.s_zero) begin
      miss_fail = 1'b1;
    end else if (stat.pct_live) begin
      miss_op = DP_BT_PCT;
    end else if (stat.star_live && !stat.star_end) begin
      miss_op = DP_BT_STAR;
    end else begin
      miss_fail = 1'b1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    res_nxt     = res_r;
    cmd.op      = DP_NOP;
    cmd.esc_rd  = 1'b0;
    cmd.esc_cmp = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_opcode == OP_EVAL) begin
            if (stat.ovf) begin
              res_nxt   = 1'b0;
              state_nxt = S_FIN;
            end else begin
              cmd.op    = DP_START;
              state_nxt = S_RD;
            end
          end else if (in_opcode inside {OP_MASK, OP_SUBJ}) begin
            cmd.op = DP_LOAD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        if (stat.c_star) begin
          cmd.op    = DP_STAR;
          state_nxt = S_RD;
        end else if (stat.c_pct) begin
          cmd.op    = DP_PCT;
          state_nxt = S_RD;
        end else if (stat.c_qm) begin
          if (stat.s_zero) begin
            res_nxt   = 1'b0;
            state_nxt = S_FIN;
          end else begin
            cmd.op    = DP_QM;
            state_nxt = S_RD;
          end
        end else if (stat.c_zero && (stat.s_zero || stat.just)) begin
          res_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (stat.c_bs) begin
          cmd.esc_rd = 1'b1;
          state_nxt  = S_ESC;
        end else if (stat.eq) begin
          cmd.op    = DP_ADV;
          state_nxt = S_RD;
        end else if (miss_fail) begin
          res_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = miss_op;
          state_nxt = S_RD;
        end
      end
      S_ESC: begin
        cmd.esc_cmp = 1'b1;
        if (stat.eq) begin
          cmd.op    = stat.nx_lit ? DP_ADV2 : DP_ADV;
          state_nxt = S_RD;
        end else if (miss_fail) begin
          res_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = miss_op;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.op    = DP_CLEAR;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == S_FIN && slot_free) begin
      out_match_r <= res_r;
      out_ovf_r   <= stat.ovf;
    end
  end

  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && slot_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished walk did not load the result register");

  a_backtrack_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_BT_PCT || cmd.op == DP_BT_STAR || cmd.op == DP_ADV2) |->
    (state_r == S_EV || state_r == S_ESC))
    else $error("walk step issued outside the walk");

  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_match_r && out_ovf_r))
    else $error("overflowed evaluate reported a match");

  a_clear_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_CLEAR) |=> !stat.ovf)
    else $error("overflow flag survived the clear");

endmodule

`default_nettype wire

// ===== hdl/wildcard_mask_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_mask_matcher: case-insensitive wildcard mask match engine
// Loads a mask and a subject byte by byte and reports whether they match.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions carry an opcode and a byte. Opcode 0 appends the byte
//   to the mask store, opcode 1 to the subject store; zero bytes are dropped,
//   and an append to a full store sets the overflow flag. Opcode 2 evaluates
//   the match, emits one result transaction and empties both stores. Opcode 3
//   is ignored. Mask syntax: '*' any run, '%' any run without a space, '?'
//   one byte, backslash before '*' or '?' makes it literal; letters compare
//   without regard to case.
//   Loads are taken while the controller is idle. An evaluate starts the
//   walk, then spends a RAM read state and a decide state on each walk step
//   (set by the registered read port of the stores), an escape state on each
//   escape backslash seen, and ends in the finish state; the step count
//   depends on the data and grows with backtracking. An overflowed evaluate
//   goes straight to the finish state. No new transaction is taken until
//   the walk is through and the controller is idle again.
//   Reset clears the fill counts, the overflow flag and the output valid flag;
//   store contents are left as they are. A stalled receiver holds the result
//   in the output register; loads keep being accepted meanwhile, and a walk
//   that finishes waits in its finish cycle until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_mask_matcher import wmm_pkg::*; #(
  parameter int MASK_DEPTH    = 64,
  parameter int SUBJECT_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [1:0] opcode, [9:2] data_byte, [15:10] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // [0] matched, [1] overflow, [7:2] zero
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     matched, overflow;

  // Controller: handshakes, walk sequencing and the result register.
  wmm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_opcode    (in_tdata[1:0]),
    .in_tready    (in_tready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_matched  (matched),
    .out_overflow (overflow),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Datapath: stores, pointers and the byte compare.
  wmm_dp #(
    .MASK_DEPTH    (MASK_DEPTH),
    .SUBJECT_DEPTH (SUBJECT_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_opcode    (in_tdata[1:0]),
    .in_data_byte (in_tdata[9:2]),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Pack the result fields, lowest bit first.
  assign out_tdata = {6'd0, overflow, matched};

endmodule

`default_nettype wire

// ===== dv/tb_wildcard_mask_matcher.sv =====
// ----------------------------------------------------------------------------
// tb_wildcard_mask_matcher: self-checking bench for the wildcard mask matcher
// Streams mask, subject and evaluate transactions into the block, predicts
// each verdict with a behavioral glob walker, and compares every result
// transaction field by field under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wildcard_mask_matcher import wmm_pkg::*;;

  localparam int    MASK_DEPTH    = 64;
  localparam int    SUBJECT_DEPTH = 256;
  localparam int    CYCLE_LIMIT   = 2_000_000;
  localparam int    SETTLE_CYCLES = 24;
  localparam int    RANDOM_ITEMS  = 450;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Walk bound: large enough that no legal walk ever reaches it.
  localparam longint STEP_CAP = (longint'(SUBJECT_DEPTH) + 2) *
                                (2 * longint'(SUBJECT_DEPTH) + 4) *
                                (longint'(MASK_DEPTH) + 2) + 16;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [1:0] opcode, [9:2] data_byte, [15:10] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] matched, [1] overflow, [7:2] zero

  // Shadow copy of the block's stores.
  logic [7:0] pat_bytes[$];
  logic [7:0] txt_bytes[$];
  bit         ovf_pending;

  // Verdicts predicted at evaluate acceptance, oldest first.
  verdict_t   verdicts_due[$];

  // Sequence under construction, sent by send_sequence.
  logic [7:0] mask_src[$];
  logic [7:0] text_src[$];

  bit gaps_on;
  bit stalls_on;
  int errors;
  int items_sent;
  int evals_checked;
  int hits_seen;
  int ovf_results;
  int cycle_count;

  wildcard_mask_matcher #(
    .MASK_DEPTH    (MASK_DEPTH),
    .SUBJECT_DEPTH (SUBJECT_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] pat_at(int i);
    return (i < pat_bytes.size()) ? pat_bytes[i] : 8'h00;
  endfunction

  function automatic logic [7:0] txt_at(int i);
    return (i < txt_bytes.size()) ? txt_bytes[i] : 8'h00;
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  // Greedy glob walk; the '%' resume point wins over the '*' resume point.
  function automatic bit glob_hits();
    int         m, n, pm, pn, ma, na;
    bit         pct_live, star_live, just;
    logic [7:0] c, s, nx;
    longint     steps;
    m = 0; n = 0; pm = 0; pn = 0; ma = 0; na = 0;
    pct_live = 1'b0; star_live = 1'b0; just = 1'b0;
    steps = 0;
    while (1) begin
      steps++;
      if (steps > STEP_CAP) return 1'b0;
      c = pat_at(m);
      s = txt_at(n);
      if (c == CH_STAR) begin
        m++;
        ma = m;
        na = n;
        star_live = 1'b1;
        just = 1'b1;
        continue;
      end
      if (c == CH_PCT) begin
        m++;
        pm = m;
        pn = n;
        pct_live = (s != CH_SPACE);
        continue;
      end
      if (c == CH_QMARK) begin
        m++;
        // a '?' at the end of the subject fails outright, no backtrack
        if (s == 8'h00) return 1'b0;
        n++;
        continue;
      end
      if (c == 8'h00) begin
        if (s == 8'h00 || just) return 1'b1;
      end else if (c == CH_BSLASH) begin
        nx = pat_at(m + 1);
        if (nx == CH_STAR || nx == CH_QMARK) begin
          m++;
          c = nx;
        end
      end
      just = 1'b0;
      if (fold_case(c) != fold_case(s)) begin
        if (s == 8'h00) return 1'b0;
        if (pct_live) begin
          m = pm;
          pn++;
          n = pn;
          if (txt_at(n) == CH_SPACE) pct_live = 1'b0;
        end else if (star_live) begin
          m = ma;
          na++;
          n = na;
          if (txt_at(n) == 8'h00) return 1'b0;
        end else begin
          return 1'b0;
        end
      end else begin
        m++;
        n++;
      end
    end
  endfunction

  // Update the shadow stores, or predict a verdict, for one accepted transaction.
  function automatic void predict_item(logic [1:0] op, logic [7:0] d);
    verdict_t v;
    case (op)
      OP_MASK: begin
        if (d != 8'h00) begin
          if (pat_bytes.size() < MASK_DEPTH) pat_bytes.push_back(d);
          else ovf_pending = 1'b1;
        end
      end
      OP_SUBJ: begin
        if (d != 8'h00) begin
          if (txt_bytes.size() < SUBJECT_DEPTH) txt_bytes.push_back(d);
          else ovf_pending = 1'b1;
        end
      end
      OP_EVAL: begin
        v.overflow = ovf_pending;
        v.matched  = ovf_pending ? 1'b0 : glob_hits();
        verdicts_due.push_back(v);
        pat_bytes.delete();
        txt_bytes.delete();
        ovf_pending = 1'b0;
      end
      default: begin
        // unused opcode: no effect
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  // Mostly back-to-back, sometimes short gaps, rarely long ones.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {6'b0, d, op};
    do @(posedge clk); while (!in_tready);
    predict_item(op, d);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for every verdict, then let the block settle.
  task automatic drain();
    in_tvalid = 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_string(input string s, input bit to_mask);
    for (int i = 0; i < s.len(); i++) begin
      if (to_mask) mask_src.push_back(s[i]);
      else text_src.push_back(s[i]);
    end
  endtask

  // Interleave the queued mask and subject bytes, optionally salted with
  // zero-byte appends and unused opcodes, then evaluate.
  task automatic send_sequence(input bit with_noise);
    int  mi, si;
    bit  take_mask;
    mi = 0;
    si = 0;
    while (mi < mask_src.size() || si < text_src.size()) begin
      take_mask = (si >= text_src.size()) ||
                  (mi < mask_src.size() && $urandom_range(0, 1) == 1);
      if (take_mask) begin
        send_item(OP_MASK, mask_src[mi]);
        mi++;
      end else begin
        send_item(OP_SUBJ, text_src[si]);
        si++;
      end
      if (with_noise && $urandom_range(0, 99) < 6) begin
        if ($urandom_range(0, 2) == 0) send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
        else send_item(1'($urandom_range(0, 1)) ? OP_MASK : OP_SUBJ, 8'h00);
      end
    end
    send_item(OP_EVAL, 8'($urandom_range(0, 255)));
    mask_src.delete();
    text_src.delete();
  endtask

  function automatic logic [7:0] pick_text_byte();
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      b = 8'h61 + 8'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 1) b ^= 8'h20;
      return b;
    end
    if (r < 60) return CH_SPACE;
    if (r < 72) begin
      case ($urandom_range(0, 3))
        0: return CH_STAR;
        1: return CH_QMARK;
        2: return CH_PCT;
        default: return CH_BSLASH;
      endcase
    end
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] b);
    if (((b | 8'h20) >= "a") && ((b | 8'h20) <= "z") && $urandom_range(0, 1) == 1)
      return b ^ 8'h20;
    return b;
  endfunction

  // Build a mask from the queued subject so that most walks go deep.
  function automatic void derive_mask();
    int         i, r, skip;
    logic [7:0] b;
    i = 0;
    while (i < text_src.size()) begin
      r = $urandom_range(0, 99);
      if (r < 10 || (r >= 10 && r < 18)) begin
        mask_src.push_back(r < 10 ? CH_STAR : CH_PCT);
        skip = $urandom_range(0, 3);
        i += (skip > text_src.size() - i) ? text_src.size() - i : skip;
      end else if (r < 28) begin
        mask_src.push_back(CH_QMARK);
        i++;
      end else if (r < 32) begin
        mask_src.push_back(pick_text_byte());
        i++;
      end else begin
        b = text_src[i];
        if ((b == CH_STAR || b == CH_QMARK) && $urandom_range(0, 3) != 0)
          mask_src.push_back(CH_BSLASH);
        mask_src.push_back(flip_case(b));
        i++;
      end
    end
    if ($urandom_range(0, 9) == 0) mask_src.push_back($urandom_range(0, 1) ? CH_STAR : CH_PCT);
  endfunction

  // ---------------------------------------------------------------- sink side

  // Sink stalls: mostly ready, short stalls common, long stalls rare.
  initial begin
    int hold;
    out_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (!stalls_on) begin
        out_tready = 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 99) < 70) begin
        out_tready = 1'b1;
      end else begin
        out_tready = 1'b0;
        hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(9, 40);
      end
    end
  end

  // Compare each result transaction against the oldest predicted verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, got tdata=%02h",
                 $time, out_tdata);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        evals_checked++;
        if (out_tdata[0]) hits_seen++;
        if (out_tdata[1]) ovf_results++;
        if (out_tdata[0] !== want.matched) begin
          $display("%0t: matched mismatch, expected %0b, got %0b",
                   $time, want.matched, out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== want.overflow) begin
          $display("%0t: overflow mismatch, expected %0b, got %0b",
                   $time, want.overflow, out_tdata[1]);
          errors++;
        end
        if (out_tdata[7:2] !== 6'b0) begin
          $display("%0t: tdata padding mismatch, expected 00, got %02h",
                   $time, out_tdata[7:2]);
          errors++;
        end
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time, verdicts_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // Empty stores match; an unused opcode and a zero byte change nothing.
  task automatic test_empty_and_noise();
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_SUBJ, 8'h00);
    send_item(OP_EVAL, 8'h00);
    drain();
  endtask

  // '%' stops at a space, '?' at the end of the subject fails, '*' spans.
  task automatic test_wildcards();
    queue_string("%b", 1'b1);
    queue_string("a b", 1'b0);
    send_sequence(1'b0);
    queue_string("?", 1'b1);
    send_sequence(1'b0);
    queue_string("*", 1'b1);
    queue_string("x", 1'b0);
    send_sequence(1'b0);
    drain();
  endtask

  // Escaped '?', a trailing backslash as a plain byte, and case folding.
  task automatic test_escapes_and_case();
    queue_string("\\?", 1'b1);
    queue_string("?", 1'b0);
    send_sequence(1'b0);
    queue_string("a\\", 1'b1);
    queue_string("A\\", 1'b0);
    send_sequence(1'b0);
    drain();
  endtask

  // Fill each store exactly, then past its depth.
  task automatic test_store_capacity();
    logic [7:0] b;
    // full mask, exact fit
    for (int i = 0; i < MASK_DEPTH; i++) begin
      b = 8'h61 + 8'($urandom_range(0, 25));
      text_src.push_back(b);
      mask_src.push_back($urandom_range(0, 4) == 0 ? CH_QMARK : flip_case(b));
    end
    send_sequence(1'b0);
    // full subject, exact fit; a zero byte on a full store is still dropped
    for (int i = 0; i < SUBJECT_DEPTH; i++) text_src.push_back(8'h61 + 8'($urandom_range(0, 3)));
    mask_src.push_back(CH_STAR);
    for (int i = SUBJECT_DEPTH - 3; i < SUBJECT_DEPTH; i++) mask_src.push_back(flip_case(text_src[i]));
    for (int i = 0; i < SUBJECT_DEPTH; i++) send_item(OP_SUBJ, text_src[i]);
    send_item(OP_SUBJ, 8'h00);
    text_src.delete();
    send_sequence(1'b0);
    // mask overflow
    for (int i = 0; i < MASK_DEPTH + $urandom_range(1, 3); i++) mask_src.push_back(CH_STAR);
    queue_string("ab", 1'b0);
    send_sequence(1'b1);
    // subject overflow, then a clean evaluate to show the flag cleared
    for (int i = 0; i < SUBJECT_DEPTH + 1; i++) text_src.push_back(pick_text_byte());
    queue_string("*", 1'b1);
    send_sequence(1'b0);
    send_item(OP_EVAL, 8'h5A);
    drain();
  endtask

  // Random sequences: mostly masks derived from their subject, the rest
  // free-form, with random gap and stall regimes per sequence.
  task automatic test_random_matches();
    int goal, r, len;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      r = $urandom_range(0, 9);
      gaps_on   = (r >= 2);
      stalls_on = (r >= 2) || (r == 0);
      len = $urandom_range(0, 20);
      for (int i = 0; i < len; i++) text_src.push_back(pick_text_byte());
      if ($urandom_range(0, 99) < 65) begin
        derive_mask();
      end else begin
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 9))
            0: mask_src.push_back(CH_STAR);
            1: mask_src.push_back(CH_PCT);
            2: mask_src.push_back(CH_QMARK);
            3: mask_src.push_back(CH_BSLASH);
            default: mask_src.push_back(pick_text_byte());
          endcase
        end
      end
      send_sequence(1'b1);
    end
    drain();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 16'h0000;
    ovf_pending = 1'b0;
    gaps_on     = 1'b0;
    stalls_on   = 1'b0;
    errors      = 0;
    items_sent  = 0;
    evals_checked = 0;
    hits_seen   = 0;
    ovf_results = 0;
    cycle_count = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_and_noise();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_wildcards();
    test_escapes_and_case();
    test_store_capacity();
    test_random_matches();

    $display("Sent %0d input transactions; checked %0d verdicts (%0d matches, %0d overflows).",
             items_sent, evals_checked, hits_seen, ovf_results);
    $display("Covered wildcards, escapes, case folding, zero bytes, unused opcodes, full stores.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/wmm_pkg.sv
hdl/wmm_ram.sv
hdl/wmm_dp.sv
hdl/wmm_ctrl.sv
hdl/wildcard_mask_matcher.sv
dv/tb_wildcard_mask_matcher.sv
